// ===== src/ccli_pkg.sv =====
// Shared types and constants for the cyclic cubic Lagrange interpolator.
package ccli_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    localparam logic [1:0] ST_VALUE = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [15:0] GRID_RESET = 16'd40;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] position;
        logic [31:0] obs_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] interp_value;
    } out_item_t;

endpackage

// ===== src/ccli_if.sv =====
// Valid/ready channel interfaces for command input and result output.
interface ccli_in_if;
    import ccli_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ccli_out_if;
    import ccli_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/cyclic_cubic_lagrange_interp.sv =====
// Cyclic cubic Lagrange interpolator: table load, search and shared-unit evaluation.
//
// Usage: send items on in_ch (valid/ready). command CLEAR empties the point table,
// LOAD appends a point (strictly ascending positions below grid_size), QUERY
// returns the value at a grid index: the stored value on a hit, else the cubic
// Lagrange value through the two points around the gap and one more on each side,
// positions unwrapped cyclically. Each of the four terms truncates toward zero,
// the sum saturates to signed Q16.16. One result item per input item on out_ch.
// grid_size must be written through cfg_we/cfg_data only while the block is idle;
// the block itself does not enforce this. Clear, load and errors go straight to
// the result; a query searches the table entries in order, and a hit on entry j
// ends the search there. An interpolating query searches up to the gap entry j,
// reads four nodes, then per node runs nine passes through one shared 36x18
// multiplier (six node differences, three slices of numerator times sample), a
// restoring division of 128 quotient bits and an accumulate step. One item is in
// work at a time; in_ch.ready is high only in idle, so a new item is taken only
// after the previous one finishes. Reset clears the point count, sets grid_size to
// 40 and empties the output. A stalled receiver holds the result in the output
// register; the next item is accepted meanwhile and its result waits until that
// register frees.
module cyclic_cubic_lagrange_interp #(
    parameter int MAX_POINTS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    ccli_in_if.sink             in_ch,
    ccli_out_if.source          out_ch
);
    import ccli_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_SREAD, S_NODE, S_NREAD, S_PROD, S_MUL, S_ACC, S_DIV,
        S_SUM, S_DONE
    } state_t;

    logic [15:0] pos_mem [MAX_POINTS];
    logic [31:0] val_mem [MAX_POINTS];
    logic [AW-1:0] rd_addr;
    logic [15:0] rd_pos;
    logic [31:0] rd_val;

    state_t        state_reg;
    logic [15:0]   grid_reg;
    logic [CW-1:0] count_reg;
    logic [15:0]   last_reg;
    logic [15:0]   qpos_reg;
    logic [CW-1:0] j_reg;
    logic [AW-1:0] left_reg;
    logic [1:0]    k_reg;
    logic [17:0]   node_reg [4];
    logic signed [31:0] zval_reg [4];
    logic [17:0]   nq_reg;
    logic [4:0]    pstep_reg;
    logic [53:0]   num_reg, den_reg;
    logic          num_neg_reg, den_neg_reg;
    logic [35:0]   ma_reg;
    logic [17:0]   mb_reg;
    logic [53:0]   mul_out;
    logic [127:0]  dvd_reg;
    logic [63:0]   dvs_reg, rem_reg;
    logic [6:0]    bit_reg;
    logic          neg_reg;
    logic signed [129:0] sum_reg;
    logic          ovalid_reg;
    out_item_t     res_reg;
    out_item_t     opay_reg;

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = ovalid_reg;
    assign out_ch.payload = opay_reg;

    wire accept = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk)
    begin
        if (accept && in_ch.payload.command == CMD_LOAD && count_reg < CW'(MAX_POINTS)
            && in_ch.payload.position < grid_reg
            && (count_reg == '0 || in_ch.payload.position > last_reg))
        begin
            pos_mem[count_reg[AW-1:0]] <= in_ch.payload.position;
            val_mem[count_reg[AW-1:0]] <= in_ch.payload.obs_value;
        end
        rd_pos <= pos_mem[rd_addr];
        rd_val <= val_mem[rd_addr];
    end

    // cyclic unwrap: base + ((x - base) mod N), x already below N, base below 2N
    function automatic logic [17:0] unwrap(input logic [17:0] base, input logic [15:0] x,
                                           input logic [15:0] n);
        logic [17:0] b;
        b = {2'b00, 16'(base)};
        if (base >= {2'b00, n}) b = base - {2'b00, n};
        if ({2'b00, x} >= b) return base + ({2'b00, x} - b);
        return base + ({2'b00, x} + {2'b00, n} - b);
    endfunction

    logic [AW-1:0] idx_k;
    logic [CW:0] tmp_idx;
    always_comb
    begin
        tmp_idx = {1'b0, {{(CW-AW){1'b0}}, left_reg}} + (CW+1)'(count_reg)
                  + (CW+1)'(k_reg) - (CW+1)'(1);
        if (tmp_idx >= (CW+1)'(count_reg)) tmp_idx = tmp_idx - (CW+1)'(count_reg);
        if (tmp_idx >= (CW+1)'(count_reg)) tmp_idx = tmp_idx - (CW+1)'(count_reg);
        idx_k = tmp_idx[AW-1:0];
        rd_addr = (state_reg == S_SEARCH) ? j_reg[AW-1:0] : idx_k;
    end

    // operand select for the shared multiplier: steps 0..5 are node differences
    // into num or den, steps 6..8 multiply the sample by 18-bit slices of num
    logic signed [18:0] fa;
    logic [17:0] fmag;
    logic [31:0] zmag;
    logic [1:0] oth;
    logic [35:0] ma_sel;
    logic [17:0] mb_sel;
    logic [127:0] zpart;
    always_comb
    begin
        oth = 2'(pstep_reg[2:1]);
        if (oth >= k_reg) oth = oth + 2'd1;
        if (!pstep_reg[0]) fa = signed'({1'b0, nq_reg}) - signed'({1'b0, node_reg[oth]});
        else fa = signed'({1'b0, node_reg[k_reg]}) - signed'({1'b0, node_reg[oth]});
        fmag = fa[18] ? 18'(-fa) : 18'(fa);
        zmag = zval_reg[k_reg][31] ? 32'(-zval_reg[k_reg]) : 32'(zval_reg[k_reg]);
        case (pstep_reg)
            5'd6:
            begin
                ma_sel = {4'd0, zmag};
                mb_sel = num_reg[17:0];
                zpart  = {74'd0, mul_out};
            end
            5'd7:
            begin
                ma_sel = {4'd0, zmag};
                mb_sel = num_reg[35:18];
                zpart  = {74'd0, mul_out} << 18;
            end
            5'd8:
            begin
                ma_sel = {4'd0, zmag};
                mb_sel = num_reg[53:36];
                zpart  = {74'd0, mul_out} << 36;
            end
            default:
            begin
                ma_sel = pstep_reg[0] ? den_reg[35:0] : num_reg[35:0];
                mb_sel = fmag;
                zpart  = '0;
            end
        endcase
    end

    assign mul_out = ma_reg * mb_reg;

    logic [64:0] trial;
    assign trial = {rem_reg, dvd_reg[127]} - {1'b0, dvs_reg};

    logic signed [129:0] term;
    assign term = neg_reg ? -signed'({2'b00, dvd_reg}) : signed'({2'b00, dvd_reg});

    logic signed [129:0] total;
    assign total = sum_reg + term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            grid_reg   <= GRID_RESET;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) grid_reg <= cfg_data;
            if (state_reg == S_DONE && (!ovalid_reg || out_ch.ready)) ovalid_reg <= 1'b1;
            else if (out_ch.ready) ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (accept)
                    begin
                        res_reg.interp_value <= '0;
                        qpos_reg <= in_ch.payload.position;
                        j_reg    <= '0;
                        case (in_ch.payload.command)
                            CMD_CLEAR:
                            begin
                                count_reg <= '0;
                                res_reg.status <= ST_OK;
                                state_reg <= S_DONE;
                            end
                            CMD_LOAD:
                            begin
                                if (count_reg < CW'(MAX_POINTS)
                                    && in_ch.payload.position < grid_reg
                                    && (count_reg == '0 || in_ch.payload.position > last_reg))
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    last_reg  <= in_ch.payload.position;
                                    res_reg.status <= ST_OK;
                                end
                                else
                                    res_reg.status <= ST_ERROR;
                                state_reg <= S_DONE;
                            end
                            CMD_QUERY:
                            begin
                                res_reg.status <= ST_ERROR;
                                if (count_reg < CW'(4) || in_ch.payload.position >= grid_reg
                                    || last_reg >= grid_reg)
                                    state_reg <= S_DONE;
                                else
                                    state_reg <= S_SEARCH;
                            end
                            default:
                            begin
                                res_reg.status <= ST_ERROR;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                S_SEARCH: state_reg <= S_SREAD;
                S_SREAD:
                    if (rd_pos == qpos_reg)
                    begin
                        res_reg <= '{status: ST_VALUE, interp_value: rd_val};
                        state_reg <= S_DONE;
                    end
                    else if (rd_pos > qpos_reg || j_reg == count_reg - 1'b1)
                    begin
                        // gap found: left node is the one before, or the last entry when wrapping
                        if (rd_pos > qpos_reg && j_reg != '0)
                            left_reg <= AW'(j_reg - 1'b1);
                        else
                            left_reg <= AW'(count_reg - 1'b1);
                        k_reg <= '0;
                        state_reg <= S_NODE;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_SEARCH;
                    end
                S_NODE: state_reg <= S_NREAD;
                S_NREAD:
                begin
                    zval_reg[k_reg] <= rd_val;
                    if (k_reg == 2'd0) node_reg[0] <= {2'b00, rd_pos};
                    else node_reg[k_reg] <= unwrap(node_reg[0], rd_pos, grid_reg);
                    if (k_reg == 2'd3)
                    begin
                        nq_reg      <= unwrap(node_reg[1], qpos_reg, grid_reg);
                        k_reg       <= '0;
                        pstep_reg   <= '0;
                        num_reg     <= 54'd1;
                        den_reg     <= 54'd1;
                        num_neg_reg <= 1'b0;
                        den_neg_reg <= 1'b0;
                        dvd_reg     <= '0;
                        sum_reg     <= '0;
                        state_reg   <= S_PROD;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_NODE;
                    end
                end
                S_PROD:
                begin
                    // load the shared multiplier; track the sign of each node difference
                    ma_reg <= ma_sel;
                    mb_reg <= mb_sel;
                    if (pstep_reg < 5'd6)
                    begin
                        if (pstep_reg[0]) den_neg_reg <= den_neg_reg ^ fa[18];
                        else num_neg_reg <= num_neg_reg ^ fa[18];
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (pstep_reg < 5'd6)
                    begin
                        if (pstep_reg[0]) den_reg <= mul_out;
                        else num_reg <= mul_out;
                    end
                    else
                        dvd_reg <= dvd_reg + zpart;
                    pstep_reg <= pstep_reg + 1'b1;
                    if (pstep_reg == 5'd8) state_reg <= S_ACC;
                    else state_reg <= S_PROD;
                end
                S_ACC:
                begin
                    // divide |z*num| by |den|, one quotient bit per cycle
                    dvs_reg <= {10'd0, den_reg};
                    rem_reg <= '0;
                    neg_reg <= (zval_reg[k_reg] != 0 && num_reg != '0)
                               && ((zval_reg[k_reg][31] ^ num_neg_reg) ^ den_neg_reg);
                    bit_reg <= 7'd127;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!trial[64]) rem_reg <= trial[63:0];
                    else rem_reg <= {rem_reg[62:0], dvd_reg[127]};
                    dvd_reg <= {dvd_reg[126:0], ~trial[64]};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == 7'd0) state_reg <= S_SUM;
                end
                S_SUM:
                    // add the term; continue with the next node or saturate
                    if (k_reg == 2'd3)
                    begin
                        if (total > 130'sd2147483647)
                            res_reg <= '{status: ST_VALUE, interp_value: 32'h7FFFFFFF};
                        else if (total < -130'sd2147483648)
                            res_reg <= '{status: ST_VALUE, interp_value: 32'h80000000};
                        else
                            res_reg <= '{status: ST_VALUE, interp_value: 32'(total)};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sum_reg     <= total;
                        k_reg       <= k_reg + 1'b1;
                        pstep_reg   <= '0;
                        num_reg     <= 54'd1;
                        den_reg     <= 54'd1;
                        num_neg_reg <= 1'b0;
                        den_neg_reg <= 1'b0;
                        dvd_reg     <= '0;
                        state_reg   <= S_PROD;
                    end
                S_DONE:
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        opay_reg  <= res_reg;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready) else $error("ready stayed high after accept");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS)) else $error("point count overflow");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !ovalid_reg) |=> ovalid_reg)
        else $error("result not issued");

endmodule
